// ===== sv/edc_pkg.sv =====
// Shared types, constants, microcode encodings and tables of the calendar converter.
package edc_pkg;

    // Payload widths
    localparam int VALUE_W = 41;
    localparam int OFS_W   = 46;
    localparam int YEAR_W  = 33;
    localparam int MONTH_W = 4;

    // Datapath widths
    localparam int DIV_W  = 42;
    localparam int REM_W  = 18;
    localparam int ACC_W  = 50;
    localparam int DAY_W  = 18;
    localparam int CYC_W  = 9;
    localparam int PC_W   = 5;

    // Reciprocal scale and width of the divider's reciprocal
    localparam int RCP_S  = 41;
    localparam int RCP_W  = 38;

    // Calendar constants
    localparam int EPOCH_YEAR      = 1970;
    localparam int CYCLE_DAYS      = 146097;
    localparam int EPOCH_CIVIL     = 719468;
    localparam int EPOCH_CYCLE_POS = 370;
    localparam int CYCLE_YEARS     = 400;

    localparam logic signed [OFS_W-1:0] OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};
    localparam logic signed [OFS_W-1:0] OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};

    // Datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP       = 4'd0;
    localparam op_t OP_LATCH     = 4'd1;
    localparam op_t OP_DIV_START = 4'd2;
    localparam op_t OP_M0_LOAD   = 4'd3;
    localparam op_t OP_YSTEP     = 4'd4;
    localparam op_t OP_MSTEP     = 4'd5;
    localparam op_t OP_M0_OFS    = 4'd6;
    localparam op_t OP_M0_FIN    = 4'd7;
    localparam op_t OP_SPLIT12   = 4'd8;
    localparam op_t OP_YSET      = 4'd9;
    localparam op_t OP_ACC365    = 4'd10;
    localparam op_t OP_SUB_Q     = 4'd11;
    localparam op_t OP_ADD_Q     = 4'd12;
    localparam op_t OP_EMIT      = 4'd13;

    // Jump conditions
    typedef logic [3:0] cond_t;
    localparam cond_t C_NEXT      = 4'd0;
    localparam cond_t C_ALWAYS    = 4'd1;
    localparam cond_t C_NO_ITEM   = 4'd2;
    localparam cond_t C_MODE1     = 4'd3;
    localparam cond_t C_UNIT_YEAR = 4'd4;
    localparam cond_t C_DIV_BUSY  = 4'd5;
    localparam cond_t C_YEAR_MORE = 4'd6;
    localparam cond_t C_MON_MORE  = 4'd7;
    localparam cond_t C_OUT_FULL  = 4'd8;

    // Divisor select
    typedef logic [1:0] dsel_t;
    localparam dsel_t DS_CYCLE   = 2'd0;
    localparam dsel_t DS_MONTHS  = 2'd1;
    localparam dsel_t DS_CENTURY = 2'd2;
    localparam dsel_t DS_QUAD    = 2'd3;

    // Dividend select
    localparam logic SRC_V = 1'b0;
    localparam logic SRC_Y = 1'b1;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        dsel_t           dsel;
        logic            src_y;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic mode;
        logic unit_year;
        logic div_busy;
        logic year_more;
        logic mon_more;
        logic out_full;
    } stat_t;

    // Constant divisor for the shared divider
    function automatic logic [REM_W-1:0] div_const(input dsel_t sel);
        logic [REM_W-1:0] d;
        case (sel)
            DS_CYCLE:   d = REM_W'(CYCLE_DAYS);
            DS_MONTHS:  d = REM_W'(12);
            DS_CENTURY: d = REM_W'(100);
            default:    d = REM_W'(CYCLE_YEARS);
        endcase
        return d;
    endfunction

    // Scaled reciprocal of the divisor, rounded down
    function automatic logic [RCP_W-1:0] div_recip(input dsel_t sel);
        logic [RCP_W-1:0] m;
        case (sel)
            DS_CYCLE:   m = RCP_W'((64'd1 << RCP_S) / 64'(CYCLE_DAYS));
            DS_MONTHS:  m = RCP_W'((64'd1 << RCP_S) / 64'd12);
            DS_CENTURY: m = RCP_W'((64'd1 << RCP_S) / 64'd100);
            default:    m = RCP_W'((64'd1 << RCP_S) / 64'(CYCLE_YEARS));
        endcase
        return m;
    endfunction

    // Days in month, February as a common year
    function automatic logic [4:0] mon_len(input logic [3:0] mon);
        logic [4:0] n;
        case (mon)
            4'd1:                   n = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: n = 5'd30;
            default:                n = 5'd31;
        endcase
        return n;
    endfunction

    // Day offset of a month's first day within a March-based year, by month index 0..11
    function automatic logic [8:0] civ_off(input logic [3:0] mr);
        logic [8:0] n;
        case (mr)
            4'd0:    n = 9'd306;
            4'd1:    n = 9'd337;
            4'd2:    n = 9'd0;
            4'd3:    n = 9'd31;
            4'd4:    n = 9'd61;
            4'd5:    n = 9'd92;
            4'd6:    n = 9'd122;
            4'd7:    n = 9'd153;
            4'd8:    n = 9'd184;
            4'd9:    n = 9'd214;
            4'd10:   n = 9'd245;
            default: n = 9'd275;
        endcase
        return n;
    endfunction

endpackage

// ===== sv/edc_in_if.sv =====
// Input item channel: conversion mode and value.
interface edc_in_if import edc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, mode, value, input ready);
    modport sink   (input valid, mode, value, output ready);
endinterface

// ===== sv/edc_out_if.sv =====
// Result item channel: offset or day count, calendar year and month, saturation flag.
interface edc_out_if import edc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [OFS_W-1:0]  offset_or_days;
    logic signed [YEAR_W-1:0] calendar_year;
    logic [MONTH_W-1:0]       calendar_month;
    logic                     saturated;

    modport source (output valid, offset_or_days, calendar_year, calendar_month, saturated,
                    input ready);
    modport sink   (input valid, offset_or_days, calendar_year, calendar_month, saturated,
                    output ready);
endinterface

// ===== sv/edc_cfg_if.sv =====
// Configuration write channel carrying the unit select.
interface edc_cfg_if;
    logic valid;
    logic ready;
    logic unit_is_month;

    modport source (output valid, unit_is_month, input ready);
    modport sink   (input valid, unit_is_month, output ready);
endinterface

// ===== sv/epoch_day_year_month_convert.sv =====
// Gregorian calendar converter. One item is worked at a time. Mode 0 (day count to
// year/month) walks Y (0..399) years inside the 400-year cycle, one year per cycle, and
// then M (0..11) months. Mode 1 (offset to day count) runs two divisions on the shared
// divider for year units and three for month units. A stalled output holds the block
// at its emit step until the output register is free. A finished result waits in an
// output register, so the next item is taken while it is still unread. The unit select
// is written through the configuration channel, which is always ready, and must only
// change while idle.
module epoch_day_year_month_convert import edc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    edc_in_if.sink    data,
    edc_out_if.source result,
    edc_cfg_if.sink   cfg
);

    logic  unit_reg, unit_next;
    ctrl_t ctrl;
    stat_t stat;

    // Hold the unit select
    assign cfg.ready = 1'b1;
    assign unit_next = cfg.valid ? cfg.unit_is_month : unit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= 1'b0;
        end
        else
        begin
            unit_reg <= unit_next;
        end
    end

    // Take an item only at the idle step
    assign data.ready = (ctrl.op == OP_LATCH);

    edc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    edc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .in_valid       (data.valid),
        .in_mode        (data.mode),
        .in_value       (data.value),
        .unit_is_month  (unit_reg),
        .out_ready      (result.ready),
        .out_valid      (result.valid),
        .offset_or_days (result.offset_or_days),
        .calendar_year  (result.calendar_year),
        .calendar_month (result.calendar_month),
        .saturated      (result.saturated),
        .stat           (stat)
    );

endmodule

// ===== sv/edc_div.sv =====
// Shared divider by a constant: reciprocal multiply in partial products, floor quotient.
module edc_div import edc_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  dsel_t                   dsel,
    input  logic signed [DIV_W-1:0] dividend,
    output logic                    busy,
    output logic signed [DIV_W-1:0] quot,
    output logic [REM_W-1:0]        rem
);

    localparam int MAG_W  = DIV_W - 1;
    localparam int NL_W   = 21;
    localparam int ML_W   = 19;
    localparam int PP_W   = NL_W + ML_W;
    localparam int PROD_W = MAG_W + RCP_W;
    localparam int R_W    = REM_W + 2;
    localparam int STEP_W = 3;

    // Steps: four partial products, the remainder, one correction
    localparam logic [STEP_W-1:0] ST_PP0 = 3'd0;
    localparam logic [STEP_W-1:0] ST_PP1 = 3'd1;
    localparam logic [STEP_W-1:0] ST_PP2 = 3'd2;
    localparam logic [STEP_W-1:0] ST_PP3 = 3'd3;
    localparam logic [STEP_W-1:0] ST_REM = 3'd4;
    localparam logic [STEP_W-1:0] ST_FIX = 3'd5;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg;
    dsel_t             dsel_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [R_W-1:0]    rem_reg;

    logic [REM_W-1:0]  divisor;
    logic [RCP_W-1:0]  recip;
    logic [NL_W-1:0]   n_part;
    logic [ML_W-1:0]   m_part;
    logic [PP_W-1:0]   pp;
    logic [PROD_W-1:0] pp_sh;
    logic [DIV_W-1:0]  q_est;
    logic [R_W-1:0]    qd_low;

    assign divisor = div_const(dsel_reg);
    assign recip   = div_recip(dsel_reg);

    // Pick one partial product of magnitude times reciprocal
    always_comb
    begin
        n_part = step_reg[1] ? NL_W'(mag_reg[MAG_W-1:NL_W]) : mag_reg[NL_W-1:0];
        m_part = step_reg[0] ? recip[RCP_W-1:ML_W] : recip[ML_W-1:0];
        pp     = PP_W'(n_part) * PP_W'(m_part);
        unique case (step_reg)
            ST_PP1:  pp_sh = PROD_W'(pp) << ML_W;
            ST_PP2:  pp_sh = PROD_W'(pp) << NL_W;
            ST_PP3:  pp_sh = PROD_W'(pp) << (NL_W + ML_W);
            default: pp_sh = PROD_W'(pp);
        endcase
    end

    // Estimate is low by at most one; the remainder needs only its low bits
    assign q_est  = DIV_W'(prod_reg[PROD_W-1:RCP_S]);
    assign qd_low = q_est[R_W-1:0] * R_W'(divisor);

    // Advance the step counter
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = ST_PP0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 1'b1;
            busy_next = (step_reg != ST_FIX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= ST_PP0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    // Load a folded magnitude, accumulate, then fix up quotient and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[DIV_W-1];
            dsel_reg <= dsel;
            mag_reg  <= dividend[DIV_W-1] ? ~dividend[MAG_W-1:0] : dividend[MAG_W-1:0];
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            unique case (step_reg)
                ST_REM:
                begin
                    quo_reg <= q_est;
                    rem_reg <= mag_reg[R_W-1:0] - qd_low;
                end
                ST_FIX:
                begin
                    if (rem_reg >= R_W'(divisor))
                    begin
                        quo_reg <= quo_reg + 1'b1;
                        rem_reg <= rem_reg - R_W'(divisor);
                    end
                end
                default:
                begin
                    prod_reg <= prod_reg + pp_sh;
                end
            endcase
        end
    end

    // Unfold a negative dividend into floor quotient and non-negative remainder
    assign busy = busy_reg;
    assign quot = neg_reg ? $signed(~quo_reg) : $signed(quo_reg);
    assign rem  = neg_reg ? (divisor - REM_W'(1) - rem_reg[REM_W-1:0]) : rem_reg[REM_W-1:0];

endmodule

// ===== sv/edc_seq.sv =====
// Microcode sequencer: program ROM, step counter and conditional jumps.
module edc_seq import edc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    // Program steps
    localparam logic [PC_W-1:0] S_IDLE    = 5'd0;
    localparam logic [PC_W-1:0] S_MODE    = 5'd1;
    localparam logic [PC_W-1:0] S_M0_DIV  = 5'd2;
    localparam logic [PC_W-1:0] S_M0_WAIT = 5'd3;
    localparam logic [PC_W-1:0] S_M0_LOAD = 5'd4;
    localparam logic [PC_W-1:0] S_YWALK   = 5'd5;
    localparam logic [PC_W-1:0] S_MWALK   = 5'd6;
    localparam logic [PC_W-1:0] S_M0_OFS  = 5'd7;
    localparam logic [PC_W-1:0] S_M0_FIN  = 5'd8;
    localparam logic [PC_W-1:0] S_M1_UNIT = 5'd9;
    localparam logic [PC_W-1:0] S_M1_DIV  = 5'd10;
    localparam logic [PC_W-1:0] S_M1_WAIT = 5'd11;
    localparam logic [PC_W-1:0] S_SPLIT   = 5'd12;
    localparam logic [PC_W-1:0] S_YSET    = 5'd13;
    localparam logic [PC_W-1:0] S_ACC     = 5'd14;
    localparam logic [PC_W-1:0] S_C_DIV   = 5'd15;
    localparam logic [PC_W-1:0] S_C_WAIT  = 5'd16;
    localparam logic [PC_W-1:0] S_C_SUB   = 5'd17;
    localparam logic [PC_W-1:0] S_Q_DIV   = 5'd18;
    localparam logic [PC_W-1:0] S_Q_WAIT  = 5'd19;
    localparam logic [PC_W-1:0] S_Q_ADD   = 5'd20;
    localparam logic [PC_W-1:0] S_EMIT    = 5'd21;
    localparam logic [PC_W-1:0] S_DONE    = 5'd22;

    function automatic ctrl_t mk(input op_t op, input cond_t cond, input dsel_t dsel,
                                 input logic src_y, input logic [PC_W-1:0] target);
        ctrl_t w;
        w.op     = op;
        w.cond   = cond;
        w.dsel   = dsel;
        w.src_y  = src_y;
        w.target = target;
        return w;
    endfunction

    // Program ROM
    function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        unique case (pc)
            S_IDLE:    w = mk(OP_LATCH,     C_NO_ITEM,   DS_CYCLE,   SRC_V, S_IDLE);
            S_MODE:    w = mk(OP_NOP,       C_MODE1,     DS_CYCLE,   SRC_V, S_M1_UNIT);
            S_M0_DIV:  w = mk(OP_DIV_START, C_NEXT,      DS_CYCLE,   SRC_V, S_IDLE);
            S_M0_WAIT: w = mk(OP_NOP,       C_DIV_BUSY,  DS_CYCLE,   SRC_V, S_M0_WAIT);
            S_M0_LOAD: w = mk(OP_M0_LOAD,   C_NEXT,      DS_CYCLE,   SRC_V, S_IDLE);
            S_YWALK:   w = mk(OP_YSTEP,     C_YEAR_MORE, DS_CYCLE,   SRC_V, S_YWALK);
            S_MWALK:   w = mk(OP_MSTEP,     C_MON_MORE,  DS_CYCLE,   SRC_V, S_MWALK);
            S_M0_OFS:  w = mk(OP_M0_OFS,    C_NEXT,      DS_CYCLE,   SRC_V, S_IDLE);
            S_M0_FIN:  w = mk(OP_M0_FIN,    C_ALWAYS,    DS_CYCLE,   SRC_V, S_EMIT);
            S_M1_UNIT: w = mk(OP_NOP,       C_UNIT_YEAR, DS_CYCLE,   SRC_V, S_YSET);
            S_M1_DIV:  w = mk(OP_DIV_START, C_NEXT,      DS_MONTHS,  SRC_V, S_IDLE);
            S_M1_WAIT: w = mk(OP_NOP,       C_DIV_BUSY,  DS_MONTHS,  SRC_V, S_M1_WAIT);
            S_SPLIT:   w = mk(OP_SPLIT12,   C_ALWAYS,    DS_MONTHS,  SRC_V, S_ACC);
            S_YSET:    w = mk(OP_YSET,      C_NEXT,      DS_CYCLE,   SRC_V, S_IDLE);
            S_ACC:     w = mk(OP_ACC365,    C_NEXT,      DS_CYCLE,   SRC_Y, S_IDLE);
            S_C_DIV:   w = mk(OP_DIV_START, C_NEXT,      DS_CENTURY, SRC_Y, S_IDLE);
            S_C_WAIT:  w = mk(OP_NOP,       C_DIV_BUSY,  DS_CENTURY, SRC_Y, S_C_WAIT);
            S_C_SUB:   w = mk(OP_SUB_Q,     C_NEXT,      DS_CENTURY, SRC_Y, S_IDLE);
            S_Q_DIV:   w = mk(OP_DIV_START, C_NEXT,      DS_QUAD,    SRC_Y, S_IDLE);
            S_Q_WAIT:  w = mk(OP_NOP,       C_DIV_BUSY,  DS_QUAD,    SRC_Y, S_Q_WAIT);
            S_Q_ADD:   w = mk(OP_ADD_Q,     C_NEXT,      DS_QUAD,    SRC_Y, S_IDLE);
            S_EMIT:    w = mk(OP_EMIT,      C_OUT_FULL,  DS_CYCLE,   SRC_V, S_EMIT);
            S_DONE:    w = mk(OP_NOP,       C_ALWAYS,    DS_CYCLE,   SRC_V, S_IDLE);
            default:   w = mk(OP_NOP,       C_ALWAYS,    DS_CYCLE,   SRC_V, S_IDLE);
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            take;

    assign ctrl = rom(pc_reg);

    // Evaluate the jump condition
    always_comb
    begin
        unique case (ctrl.cond)
            C_NEXT:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_ITEM:   take = !stat.in_valid;
            C_MODE1:     take = stat.mode;
            C_UNIT_YEAR: take = stat.unit_year;
            C_DIV_BUSY:  take = stat.div_busy;
            C_YEAR_MORE: take = stat.year_more;
            C_MON_MORE:  take = stat.mon_more;
            C_OUT_FULL:  take = stat.out_full;
            default:     take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== sv/edc_dp.sv =====
// Datapath: working registers, year and month walk, civil formula and output register.
module edc_dp import edc_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ctrl_t                     ctrl,
    input  logic                      in_valid,
    input  logic                      in_mode,
    input  logic signed [VALUE_W-1:0] in_value,
    input  logic                      unit_is_month,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic signed [OFS_W-1:0]   offset_or_days,
    output logic signed [YEAR_W-1:0]  calendar_year,
    output logic [MONTH_W-1:0]        calendar_month,
    output logic                      saturated,
    output stat_t                     stat
);

    localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(CYCLE_YEARS - 1);

    localparam logic signed [ACC_W-1:0] K12     = 12;
    localparam logic signed [ACC_W-1:0] K365    = 365;
    localparam logic signed [ACC_W-1:0] K400    = CYCLE_YEARS;
    localparam logic signed [ACC_W-1:0] K_EPOCH = EPOCH_YEAR;
    localparam logic signed [ACC_W-1:0] K_CIVIL = EPOCH_CIVIL;
    localparam logic signed [DIV_W-1:0] Y_EPOCH    = EPOCH_YEAR;
    localparam logic signed [DIV_W-1:0] Y_EPOCH_M1 = EPOCH_YEAR - 1;

    // Working registers
    logic                      mode_reg, mode_next;
    logic signed [VALUE_W-1:0] v_reg, v_next;
    logic signed [DIV_W-1:0]   y_reg, y_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [DAY_W-1:0]          day_reg, day_next;
    logic [CYC_W-1:0]          k_reg, k_next;
    logic [CYC_W-1:0]          cyc_reg, cyc_next;
    logic [3:0]                mon_reg, mon_next;
    logic [3:0]                mr_reg, mr_next;
    logic signed [YEAR_W-1:0]  year_reg, year_next;
    logic [MONTH_W-1:0]        month_reg, month_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [OFS_W-1:0]   ofs_out_reg;
    logic signed [YEAR_W-1:0]  year_out_reg;
    logic [MONTH_W-1:0]        month_out_reg;
    logic                      sat_out_reg;

    // Divider hookup
    logic                      div_start;
    logic signed [DIV_W-1:0]   div_a;
    logic                      div_busy;
    logic signed [DIV_W-1:0]   quot;
    logic [REM_W-1:0]          rem;

    logic signed [ACC_W-1:0]   y_ext;
    logic                      leap;
    logic [8:0]                ylen;
    logic [4:0]                mlen;
    logic                      year_more;
    logic                      mon_more;
    logic                      out_full;
    logic                      emit;
    logic                      fits;

    assign div_start = (ctrl.op == OP_DIV_START);
    assign div_a     = ctrl.src_y ? y_reg : DIV_W'(v_reg);

    edc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dsel     (ctrl.dsel),
        .dividend (div_a),
        .busy     (div_busy),
        .quot     (quot),
        .rem      (rem)
    );

    // Leap rule from the position in the 400-year cycle
    assign leap = (cyc_reg[1:0] == 2'd0) && (cyc_reg != CYC_W'(100)) &&
                  (cyc_reg != CYC_W'(200)) && (cyc_reg != CYC_W'(300));
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = (mon_reg == 4'd1 && leap) ? 5'd29 : mon_len(mon_reg);

    assign year_more = day_reg >= DAY_W'(ylen);
    assign mon_more  = (day_reg >= DAY_W'(mlen)) && (mon_reg < 4'd11);

    assign y_ext = ACC_W'(y_reg);

    // Execute the current micro-op
    always_comb
    begin
        mode_next  = mode_reg;
        v_next     = v_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        day_next   = day_reg;
        k_next     = k_reg;
        cyc_next   = cyc_reg;
        mon_next   = mon_reg;
        mr_next    = mr_reg;
        year_next  = year_reg;
        month_next = month_reg;
        unique case (ctrl.op)
            OP_LATCH:
            begin
                if (in_valid)
                begin
                    mode_next = in_mode;
                    v_next    = in_value;
                end
            end
            OP_M0_LOAD:
            begin
                y_next   = quot;
                day_next = rem;
                k_next   = '0;
                cyc_next = CYC_W'(EPOCH_CYCLE_POS);
                mon_next = '0;
            end
            OP_YSTEP:
            begin
                if (year_more)
                begin
                    day_next = day_reg - DAY_W'(ylen);
                    k_next   = k_reg + 1'b1;
                    cyc_next = (cyc_reg == CYC_LAST) ? '0 : cyc_reg + 1'b1;
                end
            end
            OP_MSTEP:
            begin
                if (mon_more)
                begin
                    day_next = day_reg - DAY_W'(mlen);
                    mon_next = mon_reg + 1'b1;
                end
            end
            OP_M0_OFS:
            begin
                acc_next = y_ext * K400 + $signed({{(ACC_W-CYC_W){1'b0}}, k_reg});
            end
            OP_M0_FIN:
            begin
                year_next  = YEAR_W'(acc_reg + K_EPOCH);
                month_next = MONTH_W'(mon_reg + 4'd1);
                if (unit_is_month)
                begin
                    acc_next = acc_reg * K12 + $signed({{(ACC_W-4){1'b0}}, mon_reg});
                end
            end
            OP_SPLIT12:
            begin
                y_next  = quot + ((rem < REM_W'(2)) ? Y_EPOCH_M1 : Y_EPOCH);
                mr_next = rem[3:0];
            end
            OP_YSET:
            begin
                y_next  = DIV_W'(v_reg) + Y_EPOCH_M1;
                mr_next = '0;
            end
            OP_ACC365:
            begin
                acc_next = y_ext * K365 + (y_ext >>> 2)
                         + $signed({{(ACC_W-9){1'b0}}, civ_off(mr_reg)}) - K_CIVIL;
            end
            OP_SUB_Q:
            begin
                acc_next = acc_reg - ACC_W'(quot);
            end
            OP_ADD_Q:
            begin
                acc_next   = acc_reg + ACC_W'(quot);
                year_next  = '0;
                month_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        v_reg     <= v_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        day_reg   <= day_next;
        k_reg     <= k_next;
        cyc_reg   <= cyc_next;
        mon_reg   <= mon_next;
        mr_reg    <= mr_next;
        year_reg  <= year_next;
        month_reg <= month_next;
    end

    // Clip the accumulator into the result range
    assign fits = (&acc_reg[ACC_W-1:OFS_W-1]) || !(|acc_reg[ACC_W-1:OFS_W-1]);

    // Hand the result to the output register once it is free
    assign out_full = out_valid_reg && !out_ready;
    assign emit     = (ctrl.op == OP_EMIT) && !out_full;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ofs_out_reg   <= fits ? acc_reg[OFS_W-1:0] : (acc_reg[ACC_W-1] ? OFS_MIN : OFS_MAX);
            year_out_reg  <= year_reg;
            month_out_reg <= month_reg;
            sat_out_reg   <= !fits;
        end
    end

    assign out_valid      = out_valid_reg;
    assign offset_or_days = ofs_out_reg;
    assign calendar_year  = year_out_reg;
    assign calendar_month = month_out_reg;
    assign saturated      = sat_out_reg;

    // Report flags to the sequencer
    assign stat.in_valid  = in_valid;
    assign stat.mode      = mode_reg;
    assign stat.unit_year = !unit_is_month;
    assign stat.div_busy  = div_busy;
    assign stat.year_more = year_more;
    assign stat.mon_more  = mon_more;
    assign stat.out_full  = out_full;

endmodule

// ===== sv/edc_chk.sv =====
// Port-level checker for the calendar converter and its bind to the top level.
module edc_chk import edc_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [OFS_W-1:0]  offset_or_days,
    input logic signed [YEAR_W-1:0] calendar_year,
    input logic [MONTH_W-1:0]       calendar_month,
    input logic                     saturated
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(offset_or_days) &&
        $stable(calendar_year) && $stable(calendar_month) && $stable(saturated))
        else $error("stalled result changed");

    // One item at a time: no new item right after one is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while busy");

    // A clipped result sits at a range end and comes from a mode 1 (offset to day count) conversion
    a_sat_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
        (offset_or_days == OFS_MAX || offset_or_days == OFS_MIN) && calendar_month == '0)
        else $error("saturated result not at range end");

    // Month is 1..12 for calendar results, and zero only together with a zero year
    a_month: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> calendar_month <= MONTH_W'(12) &&
        (calendar_month != '0 || calendar_year == '0))
        else $error("bad month field");

endmodule

bind epoch_day_year_month_convert edc_chk u_edc_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (data.valid),
    .in_ready       (data.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .offset_or_days (result.offset_or_days),
    .calendar_year  (result.calendar_year),
    .calendar_month (result.calendar_month),
    .saturated      (result.saturated)
);

// ===== tb/sv/calendar_checker.sv =====
// Checker for the calendar converter: predicts every result and compares it with the block.
`timescale 1ns / 1ps

module calendar_checker
    import edc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    edc_in_if    data,
    edc_out_if   result,
    edc_cfg_if   cfg,
    output int   fails,
    output int   pending,
    output int   checked
);

    typedef struct packed {
        logic signed [OFS_W-1:0]  ofs;
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic                     sat;
    } date_result_t;

    localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam int REPORT_CAP = 40;

    date_result_t expected_dates[$];
    date_result_t got;
    date_result_t want;
    logic         months_unit = 1'b0;
    int           fail_cnt = 0;
    int           check_cnt = 0;

    // Division rounded toward minus infinity, positive divisor
    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic bit is_leap(input longint y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // Day number of the first of month m (1..12) in year y, March-based year count
    function automatic longint day_number(input longint y, input longint m);
        longint mm;
        longint yy;
        mm = (m + 9) % 12;
        yy = (mm >= 10) ? y - 1 : y;
        return 365 * yy + floor_div(yy, 4) - floor_div(yy, 100) + floor_div(yy, 400)
               + (mm * 306 + 5) / 10;
    endfunction

    // Expected result of one item under the given unit select
    function automatic date_result_t civil_convert(input logic mode,
                                                   input logic signed [VALUE_W-1:0] value,
                                                   input logic months);
        date_result_t r;
        longint       v;
        longint       cycles;
        longint       day;
        longint       yr;
        longint       mon;
        longint       year;
        longint       ofs;
        longint       yq;
        longint       mr;
        longint       mlen;
        logic         sat;
        v    = value;
        year = 0;
        mon  = 0;
        ofs  = 0;
        sat  = 1'b0;
        if (mode == 1'b0)
        begin
            // Drop whole 400-year cycles, then walk years and months from 1970
            cycles = floor_div(v, CYCLE_DAYS);
            day    = v - cycles * CYCLE_DAYS;
            yr     = EPOCH_YEAR;
            while (day >= (is_leap(yr) ? 366 : 365))
            begin
                day = day - (is_leap(yr) ? 366 : 365);
                yr  = yr + 1;
            end
            mlen = DAYS_IN_MONTH[0];
            while (mon < 11 && day >= mlen)
            begin
                day  = day - mlen;
                mon  = mon + 1;
                mlen = (mon == 1 && is_leap(yr)) ? 29 : DAYS_IN_MONTH[int'(mon)];
            end
            year = yr + cycles * CYCLE_YEARS;
            ofs  = months ? (year - EPOCH_YEAR) * 12 + mon : year - EPOCH_YEAR;
        end
        else if (months)
        begin
            // Split the month offset by floor division and modulo
            yq  = floor_div(v, 12);
            mr  = v - yq * 12;
            ofs = day_number(EPOCH_YEAR + yq, mr + 1) - day_number(EPOCH_YEAR, 1);
        end
        else
        begin
            ofs = day_number(EPOCH_YEAR + v, 1) - day_number(EPOCH_YEAR, 1);
        end
        // Clip to the output range
        if (ofs > longint'(OFS_MAX))
        begin
            ofs = OFS_MAX;
            sat = 1'b1;
        end
        if (ofs < longint'(OFS_MIN))
        begin
            ofs = OFS_MIN;
            sat = 1'b1;
        end
        r.ofs   = OFS_W'(ofs);
        r.year  = YEAR_W'(year);
        r.month = (mode == 1'b0) ? MONTH_W'(mon + 1) : '0;
        r.sat   = sat;
        return r;
    endfunction

    task automatic report(input string what, input longint got_v, input longint want_v);
        if (fail_cnt < REPORT_CAP)
        begin
            $display("%0t: result %0d, %s: got %0d, expected %0d",
                     $realtime, check_cnt, what, got_v, want_v);
        end
        fail_cnt++;
    endtask

    // Track the unit select, queue predictions, compare results in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            months_unit = 1'b0;
            expected_dates.delete();
            fails   <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                months_unit = cfg.unit_is_month;
            end
            if (result.valid && result.ready)
            begin
                got.ofs   = result.offset_or_days;
                got.year  = result.calendar_year;
                got.month = result.calendar_month;
                got.sat   = result.saturated;
                if (expected_dates.size() == 0)
                begin
                    report("item with nothing pending, offset_or_days", got.ofs, 0);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (got.ofs !== want.ofs)
                        report("offset_or_days", got.ofs, want.ofs);
                    if (got.year !== want.year)
                        report("calendar_year", got.year, want.year);
                    if (got.month !== want.month)
                        report("calendar_month", got.month, want.month);
                    if (got.sat !== want.sat)
                        report("saturated", got.sat, want.sat);
                end
                check_cnt++;
            end
            if (data.valid && data.ready)
            begin
                expected_dates.push_back(civil_convert(data.mode, data.value, months_unit));
            end
            fails   <= fail_cnt;
            pending <= expected_dates.size();
            checked <= check_cnt;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the calendar converter testbench: clock, reset, stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module tb_top;
    import edc_pkg::*;

    localparam int RANDOM_ITEMS = 1420;
    localparam int PHASES       = 6;
    localparam int DRAIN_CYCLES = 500;

    localparam logic signed [VALUE_W-1:0] VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VMAX = {1'b0, {(VALUE_W-1){1'b1}}};

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    int   checked;
    int   burst_left = 0;
    int   items_sent = 0;
    int   settings   = 0;

    edc_in_if  data ();
    edc_out_if result ();
    edc_cfg_if cfg ();

    epoch_day_year_month_convert dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (data),
        .result (result),
        .cfg    (cfg)
    );

    calendar_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .data    (data),
        .result  (result),
        .cfg     (cfg),
        .fails   (fails),
        .pending (pending),
        .checked (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Send one item; open a new burst after a random gap when the current one is used up
    task automatic push(input logic mode, input logic signed [VALUE_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 400)
                                                : $urandom_range(1, 8);
            data.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 20);
        end
        burst_left--;
        data.valid <= 1'b1;
        data.mode  <= mode;
        data.value <= value;
        do @(posedge clk); while (!data.ready);
        items_sent++;
    endtask

    // Hold the sender until every predicted item has come back
    task automatic drain();
        data.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_unit(input logic months);
        cfg.valid         <= 1'b1;
        cfg.unit_is_month <= months;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        settings++;
    endtask

    // Mix of full-range, small, mid-range, cycle-boundary and extreme values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        longint x;
        case ($urandom_range(0, 5))
            0:       x = longint'({$urandom, $urandom});
            1:       x = longint'($urandom_range(0, 20000)) - 10000;
            2:       x = longint'($urandom_range(0, 4000000)) - 2000000;
            3:       x = (longint'($urandom_range(0, 15000000)) - 7500000) * CYCLE_DAYS
                         + longint'($urandom_range(0, 6)) - 3;
            4:       x = longint'(VMAX) - longint'($urandom_range(0, 400));
            default: x = longint'(VMIN) + longint'($urandom_range(0, 400));
        endcase
        return VALUE_W'(x);
    endfunction

    // Receiver: runs of ready and stalls of random length, now and then a long stall
    initial
    begin
        int   run_left;
        logic rdy;
        run_left     = 0;
        rdy          = 1'b0;
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (run_left == 0)
            begin
                if ($urandom_range(0, 59) == 0)
                begin
                    rdy      = 1'b0;
                    run_left = $urandom_range(100, 500);
                end
                else if ($urandom_range(0, 2) == 0)
                begin
                    rdy      = 1'b0;
                    run_left = $urandom_range(1, 25);
                end
                else
                begin
                    rdy      = 1'b1;
                    run_left = $urandom_range(1, 60);
                end
            end
            else
            begin
                run_left--;
            end
            result.ready <= rdy;
        end
    end

    // Stimulus and verdict
    initial
    begin
        data.valid        = 1'b0;
        data.mode         = 1'b0;
        data.value        = '0;
        cfg.valid         = 1'b0;
        cfg.unit_is_month = 1'b0;
        rst_n             = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Year units: leap days, cycle edges, field extremes, saturation
        write_unit(1'b0);
        push(1'b0, 0);
        push(1'b0, -1);
        push(1'b0, 59);
        push(1'b0, 789);
        push(1'b0, 790);
        push(1'b0, 11016);
        push(1'b0, 146096);
        push(1'b0, 146097);
        push(1'b0, -146097);
        push(1'b0, -146098);
        push(1'b0, VMIN);
        push(1'b0, VMAX);
        push(1'b1, 0);
        push(1'b1, -1);
        push(1'b1, VMIN);
        push(1'b1, VMAX);
        drain();

        // Month units: offsets on both sides of year boundaries, extremes, and two day counts
        write_unit(1'b1);
        push(1'b1, 11);
        push(1'b1, 12);
        push(1'b1, -1);
        push(1'b1, -12);
        push(1'b1, -13);
        push(1'b1, VMIN);
        push(1'b1, VMAX);
        push(1'b0, -1);
        push(1'b0, VMIN);
        drain();

        // Random phases, alternating the unit select
        for (int p = 0; p < PHASES; p++)
        begin
            write_unit(p[0]);
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
            begin
                if ($urandom_range(0, 199) == 0)
                    drain();
                push(1'($urandom_range(0, 1)), pick_value());
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d items over %0d unit settings, both modes, extremes and cycle edges",
                 items_sent, settings);
        $display("%0d results compared, %0d field mismatches", checked, fails);
        if (fails == 0 && pending == 0)
            $display("epoch_day_year_month_convert: match");
        else
            $display("epoch_day_year_month_convert: mismatch");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #60_000_000;
        $display("timeout with %0d items outstanding", pending);
        $display("epoch_day_year_month_convert: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/edc_pkg.sv
sv/edc_in_if.sv
sv/edc_out_if.sv
sv/edc_cfg_if.sv
sv/edc_div.sv
sv/edc_seq.sv
sv/edc_dp.sv
sv/epoch_day_year_month_convert.sv
sv/edc_chk.sv
tb/sv/calendar_checker.sv
tb/sv/tb_top.sv
